>>> hw/rtl/mcrr_pkg.sv
// Shared types, constants and the CRC-16 byte step for the charger reply receiver.
// No dependencies.
package mcrr_pkg;

	localparam int MAX_DATA_BYTES = 16;
	localparam int POS_W = $clog2(MAX_DATA_BYTES + 6);
	localparam int LEN_W = $clog2(MAX_DATA_BYTES + 3);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNC_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_COUNT = 2'd3;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_OK = 2'd1;
	localparam logic [1:0] ST_CRC_ERR = 2'd2;
	localparam logic [1:0] ST_LEN_ERR = 2'd3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
		logic       charging;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] voltage;
		logic [15:0] current;
		logic [15:0] capacity;
		logic [15:0] charge_time;
		logic        full_flag;
	} out_t;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] full_current_limit;
		logic [7:0]  full_frame_count;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/modbus_charger_reply_receiver_core.sv
// Modbus RTU read-reply receiver with full-battery detection, top level.
// Registered path: input reg, then parse, CRC byte step and latch, then result reg.
// Throughput: one request per cycle unless out_stall holds the result register.
// Reset (arst_n low): parser idle, CRC 0xFFFF, latched values and full flag clear,
// registers at defaults. Depends on mcrr_pkg, mcrr_cfg_regs, mcrr_parser.
module modbus_charger_reply_receiver_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mcrr_pkg::in_t                    in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mcrr_pkg::out_t                   out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mcrr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcrr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mcrr_pkg::*;

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	out_t res;
	out_t result_s2;
	logic valid_s2;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign out_item = result_s2;

	mcrr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcrr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			result_s2 <= res;
		end
	end

endmodule

>>> hw/rtl/mcrr_cfg_regs.sv
// Configuration registers of the charger reply receiver.
// Depends on mcrr_pkg.
module mcrr_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mcrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcrr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output mcrr_pkg::cfg_t                      cfg
);
	import mcrr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= 8'd1;
			cfg_q.function_code <= 8'd3;
			cfg_q.full_current_limit <= 16'd50;
			cfg_q.full_frame_count <= 8'd120;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SLAVE_ADDR: cfg_q.slave_address <= cfg_data[7:0];
				REG_FUNC_CODE:  cfg_q.function_code <= cfg_data[7:0];
				REG_FULL_LIMIT: cfg_q.full_current_limit <= cfg_data[15:0];
				REG_FULL_COUNT: cfg_q.full_frame_count <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/mcrr_parser.sv
// Frame parser state, CRC check, value latch and full detector.
// Computes one result per request; state advances when step is high. Depends on mcrr_pkg.
module mcrr_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  mcrr_pkg::in_t  item,
	input  mcrr_pkg::cfg_t cfg,
	output mcrr_pkg::out_t res
);
	import mcrr_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_FUNC = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_WAIT = 3'd4;

	logic [2:0]       phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d, tpos;
	logic [LEN_W-1:0] len_q, len_d, bac_q, bac_d, bac_inc;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       prev_q, prev_d;
	logic [7:0]       vb_q [8];
	logic [7:0]       vb_w [8];
	logic [15:0]      mv_q [4];
	logic [15:0]      mv_d [4];
	logic [7:0]       cnt_q, cnt_d;
	logic             full_q, full_d;
	logic             take, is_idle, in_win;
	logic [POS_W-1:0] pos_off;
	logic [7:0]       b;
	logic [1:0]       status;
	logic [15:0]      cur_new;

	assign b = item.rx_byte;
	assign is_idle = !(phase_q == PH_FUNC || phase_q == PH_COUNT ||
		phase_q == PH_DATA || phase_q == PH_WAIT);
	assign tpos = is_idle ? '0 : pos_q;
	assign pos_off = tpos - POS_W'(3);
	assign in_win = (tpos >= POS_W'(3)) && (tpos <= POS_W'(10));
	assign bac_inc = bac_q + LEN_W'(1);
	assign take = !item.mode && (phase_q == PH_FUNC || phase_q == PH_COUNT ||
		phase_q == PH_DATA || (is_idle && b == cfg.slave_address));

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			vb_w[i] = vb_q[i];
		end
		if (take && in_win) begin
			vb_w[pos_off[2:0]] = b;
		end
	end

	assign cur_new = {vb_w[2], vb_w[3]};

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		len_d = len_q;
		bac_d = bac_q;
		crc_d = crc_q;
		prev_d = prev_q;
		cnt_d = cnt_q;
		full_d = full_q;
		for (int i = 0; i < 4; i++) begin
			mv_d[i] = mv_q[i];
		end
		status = ST_NONE;
		if (item.mode) begin
			phase_d = PH_IDLE;
			pos_d = '0;
			bac_d = '0;
		end else begin
			case (phase_q)
				PH_FUNC: begin
					crc_d = crc_byte(crc_q, b);
					phase_d = (b == cfg.function_code) ? PH_COUNT : PH_WAIT;
				end
				PH_COUNT: begin
					crc_d = crc_byte(crc_q, b);
					if (b == 8'd0 || {1'b0, b} > 9'(MAX_DATA_BYTES + 1)) begin
						status = ST_LEN_ERR;
						phase_d = PH_IDLE;
					end else begin
						len_d = LEN_W'(b - 8'd1);
						bac_d = '0;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					if (bac_q < len_q) begin
						crc_d = crc_byte(crc_q, b);
					end
					bac_d = bac_inc;
					if ({1'b0, bac_inc} >= {1'b0, len_q} + (LEN_W+1)'(2)) begin
						if (crc_q[7:0] == prev_q && crc_q[15:8] == b) begin
							for (int i = 0; i < 4; i++) begin
								mv_d[i] = {vb_w[2*i], vb_w[2*i+1]};
							end
							status = ST_OK;
							if (item.charging) begin
								if (cur_new <= cfg.full_current_limit) begin
									if (cnt_q < cfg.full_frame_count) begin
										cnt_d = cnt_q + 8'd1;
									end else begin
										full_d = 1'b1;
									end
								end else begin
									cnt_d = '0;
								end
							end else begin
								full_d = 1'b0;
								cnt_d = '0;
							end
						end else begin
							status = ST_CRC_ERR;
						end
						phase_d = PH_IDLE;
						bac_d = '0;
					end
				end
				PH_WAIT: ;
				default: begin
					bac_d = '0;
					pos_d = '0;
					if (b == cfg.slave_address) begin
						crc_d = crc_byte(CRC_INIT, b);
						phase_d = PH_FUNC;
					end else begin
						phase_d = PH_WAIT;
					end
				end
			endcase
			if (take) begin
				prev_d = b;
				pos_d = tpos + POS_W'(1);
			end
			if (status == ST_OK || status == ST_CRC_ERR) begin
				pos_d = '0;
			end
		end
	end

	assign res.status = status;
	assign res.voltage = mv_d[0];
	assign res.current = mv_d[1];
	assign res.capacity = mv_d[2];
	assign res.charge_time = mv_d[3];
	assign res.full_flag = full_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			len_q <= '0;
			bac_q <= '0;
			crc_q <= CRC_INIT;
			prev_q <= '0;
			cnt_q <= '0;
			full_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				vb_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				mv_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			len_q <= len_d;
			bac_q <= bac_d;
			crc_q <= crc_d;
			prev_q <= prev_d;
			cnt_q <= cnt_d;
			full_q <= full_d;
			for (int i = 0; i < 8; i++) begin
				vb_q[i] <= vb_w[i];
			end
			for (int i = 0; i < 4; i++) begin
				mv_q[i] <= mv_d[i];
			end
		end
	end

endmodule

>>> sim/mcrr_reply_checker.sv
`timescale 1ns / 1ps
// Reply checker for the charger reply receiver: tracks register writes and accepted
// requests, predicts each result and compares results field by field. Depends on mcrr_pkg.
module mcrr_reply_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  mcrr_pkg::in_t                   in_item,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  mcrr_pkg::out_t                  out_item,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mcrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcrr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                     pending,
	output int unsigned                     mismatches
);
	import mcrr_pkg::*;

	typedef enum logic [2:0] {
		AWAIT_ADDR,
		AWAIT_FUNC,
		AWAIT_COUNT,
		IN_PAYLOAD,
		SKIP_TO_GAP
	} parse_phase_t;

	cfg_t         cfg;
	parse_phase_t rx_phase;
	int           frame_pos;
	int           payload_len;
	int           payload_seen;
	logic [15:0]  run_crc;
	logic [15:0]  tail_pair;
	logic [7:0]   kept_bytes [8];
	logic [15:0]  words [4];
	logic [7:0]   low_frames;
	logic         full_seen;
	out_t         expected_replies [$];
	out_t         predicted;

	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic keep_byte(input logic [7:0] b);
		if (frame_pos >= 3 && frame_pos <= 10) begin
			kept_bytes[frame_pos - 3] = b;
		end
		tail_pair = {tail_pair[7:0], b};
		frame_pos++;
	endtask

	task automatic predict_reply(input in_t req, output out_t res);
		logic [1:0] st;
		logic [7:0] b;
		st = ST_NONE;
		b = req.rx_byte;
		if (req.mode) begin
			rx_phase = AWAIT_ADDR;
			frame_pos = 0;
			payload_seen = 0;
		end else begin
			case (rx_phase)
				AWAIT_FUNC: begin
					keep_byte(b);
					run_crc = crc16_update(run_crc, b);
					rx_phase = (b == cfg.function_code) ? AWAIT_COUNT : SKIP_TO_GAP;
				end
				AWAIT_COUNT: begin
					keep_byte(b);
					run_crc = crc16_update(run_crc, b);
					if (b == 8'd0 || int'(b) - 1 > MAX_DATA_BYTES) begin
						st = ST_LEN_ERR;
						rx_phase = AWAIT_ADDR;
					end else begin
						payload_len = int'(b) - 1;
						payload_seen = 0;
						rx_phase = IN_PAYLOAD;
					end
				end
				IN_PAYLOAD: begin
					if (payload_seen < payload_len) begin
						run_crc = crc16_update(run_crc, b);
					end
					keep_byte(b);
					payload_seen++;
					if (payload_seen >= payload_len + 2) begin
						if (run_crc[7:0] == tail_pair[15:8] && run_crc[15:8] == b) begin
							for (int i = 0; i < 4; i++) begin
								words[i] = {kept_bytes[2 * i], kept_bytes[2 * i + 1]};
							end
							st = ST_OK;
							// full detection runs on good frames only
							if (req.charging) begin
								if (words[1] <= cfg.full_current_limit) begin
									if (low_frames < cfg.full_frame_count) begin
										low_frames++;
									end else begin
										full_seen = 1'b1;
									end
								end else begin
									low_frames = '0;
								end
							end else begin
								full_seen = 1'b0;
								low_frames = '0;
							end
						end else begin
							st = ST_CRC_ERR;
						end
						rx_phase = AWAIT_ADDR;
						frame_pos = 0;
						payload_seen = 0;
					end
				end
				SKIP_TO_GAP: begin
				end
				default: begin
					frame_pos = 0;
					payload_seen = 0;
					if (b == cfg.slave_address) begin
						run_crc = crc16_update(CRC_INIT, b);
						keep_byte(b);
						rx_phase = AWAIT_FUNC;
					end else begin
						rx_phase = SKIP_TO_GAP;
					end
				end
			endcase
		end
		res.status = st;
		res.voltage = words[0];
		res.current = words[1];
		res.capacity = words[2];
		res.charge_time = words[3];
		res.full_flag = full_seen;
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	task automatic check_reply(input out_t got);
		out_t want;
		if (expected_replies.size() == 0) begin
			note_mismatch($sformatf("result with nothing expected, status %0d", got.status));
		end else begin
			want = expected_replies.pop_front();
			if (got.status !== want.status)
				note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.voltage !== want.voltage)
				note_mismatch($sformatf("voltage %h, want %h", got.voltage, want.voltage));
			if (got.current !== want.current)
				note_mismatch($sformatf("current %h, want %h", got.current, want.current));
			if (got.capacity !== want.capacity)
				note_mismatch($sformatf("capacity %h, want %h", got.capacity, want.capacity));
			if (got.charge_time !== want.charge_time)
				note_mismatch($sformatf("charge_time %h, want %h",
					got.charge_time, want.charge_time));
			if (got.full_flag !== want.full_flag)
				note_mismatch($sformatf("full_flag %b, want %b", got.full_flag, want.full_flag));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.slave_address = 8'd1;
			cfg.function_code = 8'd3;
			cfg.full_current_limit = 16'd50;
			cfg.full_frame_count = 8'd120;
			rx_phase = AWAIT_ADDR;
			frame_pos = 0;
			payload_len = 0;
			payload_seen = 0;
			run_crc = CRC_INIT;
			tail_pair = '0;
			for (int i = 0; i < 8; i++) kept_bytes[i] = '0;
			for (int i = 0; i < 4; i++) words[i] = '0;
			low_frames = '0;
			full_seen = 1'b0;
			expected_replies.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SLAVE_ADDR: cfg.slave_address = cfg_data[7:0];
					REG_FUNC_CODE:  cfg.function_code = cfg_data[7:0];
					REG_FULL_LIMIT: cfg.full_current_limit = cfg_data[15:0];
					REG_FULL_COUNT: cfg.full_frame_count = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_reply(in_item, predicted);
				expected_replies.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				check_reply(out_item);
			end
			pending <= expected_replies.size();
		end
	end

endmodule

>>> sim/tb_modbus_charger_reply_receiver_core.sv
`timescale 1ns / 1ps
// Testbench top for the charger reply receiver: clock, reset, request and register
// stimulus, receiver stalls and the verdict. Depends on mcrr_pkg and mcrr_reply_checker.
module tb_modbus_charger_reply_receiver_core;
	import mcrr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DIRECTED_ITEMS = 27;
	localparam int PHASE_ITEMS = 305;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_COUNT,
		FR_BAD_ADDR,
		FR_BAD_FUNC,
		FR_CUT,
		FR_NOISE
	} frame_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_item;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           pending;
	int unsigned           mismatches;

	logic [7:0]  frame_bytes [$];
	logic [7:0]  cur_addr;
	logic [7:0]  cur_func;
	logic [15:0] cur_limit;
	int          sent_items;
	int          burst_left;
	bit          valid_up;
	logic [15:0] stall_tick = '0;
	int unsigned cycle_count = 0;

	modbus_charger_reply_receiver_core dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	mcrr_reply_checker chk (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.pending, .mismatches
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 16'd1;
		case (stall_tick[9:8])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 1) == 0);
			2'd2: out_stall <= (stall_tick[2:0] < 3'd3);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_modbus_charger_reply_receiver_core: FAIL");
			$finish;
		end
	end

	// sender works in bursts; a gap only follows a burst that ended with valid high
	task automatic send_req(input logic mode, input logic [7:0] b, input logic chg);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			if (valid_up && $urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				valid_up = 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		valid_up = 1;
		in_item <= {mode, b, chg};
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	task automatic send_gap();
		send_req(1'b1, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_frame_bytes(input logic chg);
		foreach (frame_bytes[i]) send_req(1'b0, frame_bytes[i], chg);
	endtask

	function automatic void append_crc();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_bytes[i]) begin
			c ^= {8'h00, frame_bytes[i]};
			for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endfunction

	// hold the sender until every request has produced its result
	task automatic drain();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 0;
		end
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_all(input logic [7:0] a, input logic [7:0] f, input logic [15:0] lim,
			input logic [7:0] cnt);
		write_reg(REG_SLAVE_ADDR, {8'($urandom), a});
		write_reg(REG_FUNC_CODE, {8'($urandom), f});
		write_reg(REG_FULL_LIMIT, lim);
		write_reg(REG_FULL_COUNT, {8'($urandom), cnt});
		cfg_valid <= 1'b0;
		cur_addr = a;
		cur_func = f;
		cur_limit = lim;
	endtask

	task automatic send_random_frame();
		frame_kind_t kind;
		int          pick;
		int          dl;
		int          idx;
		logic        chg;
		logic [15:0] amps;
		pick = $urandom_range(0, 99);
		kind = pick < 58 ? FR_GOOD : pick < 66 ? FR_BAD_CRC : pick < 73 ? FR_BAD_COUNT
			: pick < 79 ? FR_BAD_ADDR : pick < 85 ? FR_BAD_FUNC : pick < 92 ? FR_CUT : FR_NOISE;
		chg = ($urandom_range(0, 4) != 0);
		frame_bytes.delete();
		case (kind)
			FR_BAD_ADDR: begin
				frame_bytes.push_back(cur_addr ^ 8'($urandom_range(1, 255)));
				repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
			end
			FR_BAD_FUNC: begin
				frame_bytes.push_back(cur_addr);
				frame_bytes.push_back(cur_func ^ 8'($urandom_range(1, 255)));
				repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
			end
			FR_BAD_COUNT: begin
				frame_bytes.push_back(cur_addr);
				frame_bytes.push_back(cur_func);
				frame_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'd0
					: 8'($urandom_range(MAX_DATA_BYTES + 2, 255)));
			end
			FR_NOISE: begin
			end
			default: begin
				dl = ($urandom_range(0, 7) == 0) ? MAX_DATA_BYTES : $urandom_range(0, MAX_DATA_BYTES);
				frame_bytes.push_back(cur_addr);
				frame_bytes.push_back(cur_func);
				frame_bytes.push_back(8'(dl + 1));
				repeat (dl) frame_bytes.push_back(8'($urandom));
				// current word sits in data bytes 2 and 3
				if (dl >= 4 && $urandom_range(0, 9) < 7) begin
					amps = 16'($urandom_range(0, cur_limit));
					frame_bytes[5] = amps[15:8];
					frame_bytes[6] = amps[7:0];
				end
				append_crc();
				if (kind == FR_BAD_CRC) begin
					idx = frame_bytes.size() - 1 - $urandom_range(0, 2);
					frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
				end
				if (kind == FR_CUT) begin
					repeat ($urandom_range(1, frame_bytes.size() - 3)) void'(frame_bytes.pop_back());
				end
			end
		endcase
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 8))
				send_req($urandom_range(0, 7) == 0, 8'($urandom), 1'($urandom));
		end else begin
			send_frame_bytes(chg);
		end
		if (kind == FR_BAD_ADDR || kind == FR_BAD_FUNC || kind == FR_CUT || kind == FR_NOISE
				|| $urandom_range(0, 2) == 0) begin
			send_gap();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		valid_up = 0;
		burst_left = 0;
		sent_items = 0;
		cur_addr = 8'd1;
		cur_func = 8'd3;
		cur_limit = 16'd50;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// good frame with an eight-byte payload and extreme words, charging at zero current
		frame_bytes = '{8'h01, 8'h03, 8'h09, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00,
			8'h00, 8'hFF};
		append_crc();
		send_frame_bytes(1'b1);
		// empty payload: CRC bytes land in the kept bytes, not charging
		frame_bytes = '{8'h01, 8'h03, 8'h01};
		append_crc();
		send_frame_bytes(1'b0);
		// count zero and count one past the limit
		frame_bytes = '{8'h01, 8'h03, 8'h00};
		send_frame_bytes(1'b1);
		frame_bytes = '{8'h01, 8'h03, 8'h12};
		send_frame_bytes(1'b0);
		// wrong address parks the parser until a gap
		frame_bytes = '{8'h00, 8'h01};
		send_frame_bytes(1'b1);
		send_gap();

		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
				0: write_all(8'h01, 8'h03, 16'd50, 8'd3);
				1: write_all(8'h00, 8'h00, 16'h0000, 8'h00);
				2: write_all(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
				3: write_all(8'($urandom), 8'($urandom), 16'($urandom_range(0, 3000)),
					8'($urandom_range(1, 6)));
				default: write_all(8'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom_range(0, 12)));
			endcase
			while (sent_items < DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS) send_random_frame();
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_modbus_charger_reply_receiver_core: PASS");
		end else begin
			$display("tb_modbus_charger_reply_receiver_core: FAIL");
		end
		$finish;
	end

endmodule
